// ----- design/lfps_pkg.sv -----
// shared types, constants and codes for the line follow pulse steering unit
package lfps_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int PULSE_W    = 16;
    localparam int SPEED_W    = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DETECT_LEVEL    = 2'd0,
        REG_PULSE_LENGTH_MS = 2'd1,
        REG_TURN_SPEED      = 2'd2,
        REG_STRAIGHT_SPEED  = 2'd3
    } cfg_reg_t;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 12'd2000;
    localparam logic [PULSE_W-1:0]  PULSE_LEN_RST  = 16'd100;
    localparam logic [SPEED_W-1:0]  TURN_SPD_RST   = 8'd150;
    localparam logic [SPEED_W-1:0]  STRAIGHT_SPD_RST = 8'd150;

    // detection pattern, left/middle/right
    localparam logic [2:0] PAT_NONE         = 3'b000;
    localparam logic [2:0] PAT_RIGHT        = 3'b001;
    localparam logic [2:0] PAT_CENTER       = 3'b010;
    localparam logic [2:0] PAT_CENTER_RIGHT = 3'b011;
    localparam logic [2:0] PAT_LEFT         = 3'b100;
    localparam logic [2:0] PAT_OUTER        = 3'b101;
    localparam logic [2:0] PAT_CENTER_LEFT  = 3'b110;
    localparam logic [2:0] PAT_ALL          = 3'b111;

    typedef enum logic [2:0] {
        ST_CENTER       = 3'd0,
        ST_LEFT         = 3'd1,
        ST_CENTER_LEFT  = 3'd2,
        ST_RIGHT        = 3'd3,
        ST_CENTER_RIGHT = 3'd4,
        ST_LOST_LEFT    = 3'd5,
        ST_LOST_RIGHT   = 3'd6,
        ST_LOST         = 3'd7
    } line_state_t;

    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_LEFT    = 2'd1,
        CMD_RIGHT   = 2'd2,
        CMD_STOP    = 2'd3
    } drive_cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_length_ms;
        logic [SPEED_W-1:0] turn_speed;
        logic [SPEED_W-1:0] straight_speed;
    } drive_cfg_t;

    typedef struct packed {
        logic [2:0]        pattern;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

endpackage

// ----- design/lfps_front.sv -----
// front stage: takes sensor transactions and thresholds them into a pattern
module lfps_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lfps_pkg::SAMPLE_W-1:0] s_sensor_left,
    input  logic [lfps_pkg::SAMPLE_W-1:0] s_sensor_middle,
    input  logic [lfps_pkg::SAMPLE_W-1:0] s_sensor_right,
    input  logic [lfps_pkg::TIME_W-1:0]   s_now_ms,
    input  logic [lfps_pkg::SAMPLE_W-1:0] detect_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lfps_pkg::sample_t             out_data
);

    logic              valid_reg;
    logic              valid_next;
    lfps_pkg::sample_t data_reg;
    lfps_pkg::sample_t data_next;
    logic              take;

    assign s_ready   = !valid_reg || out_ready;
    assign take      = s_valid && s_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take) begin
            valid_next        = 1'b1;
            data_next.pattern = {s_sensor_left > detect_level,
                                 s_sensor_middle > detect_level,
                                 s_sensor_right > detect_level};
            data_next.now_ms  = s_now_ms;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ----- design/lfps_queue.sv -----
// short fifo between the front and back stages
module lfps_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  lfps_pkg::sample_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lfps_pkg::sample_t pop_data
);

    lfps_pkg::sample_t                    entry_reg [lfps_pkg::QUEUE_DEPTH];
    logic [lfps_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [lfps_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [lfps_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [lfps_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [lfps_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [lfps_pkg::QUEUE_CNT_W-1:0]     count_next;
    logic                                 push;
    logic                                 pop;

    localparam logic [lfps_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        lfps_pkg::QUEUE_CNT_W'(lfps_pkg::QUEUE_DEPTH);
    localparam logic [lfps_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        lfps_pkg::QUEUE_PTR_W'(lfps_pkg::QUEUE_DEPTH - 1);

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/lfps_back.sv -----
// back stage: resolves line state, times correction pulses, holds the result
module lfps_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lfps_pkg::drive_cfg_t         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lfps_pkg::sample_t            in_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_drive_command,
    output logic [lfps_pkg::SPEED_W-1:0] m_drive_speed,
    output logic [2:0]                   m_line_state
);

    lfps_pkg::line_state_t          last_seen_reg;
    lfps_pkg::line_state_t          last_seen_next;
    logic                           running_reg;
    logic                           running_next;
    logic [lfps_pkg::TIME_W-1:0]    start_reg;
    logic [lfps_pkg::TIME_W-1:0]    start_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    lfps_pkg::drive_cmd_t           cmd_reg;
    lfps_pkg::drive_cmd_t           cmd_next;
    logic [lfps_pkg::SPEED_W-1:0]   speed_reg;
    logic [lfps_pkg::SPEED_W-1:0]   speed_next;
    lfps_pkg::line_state_t          state_reg;
    lfps_pkg::line_state_t          state_next;
    lfps_pkg::line_state_t          st;
    logic [lfps_pkg::TIME_W-1:0]    eff_start;
    logic [lfps_pkg::TIME_W-1:0]    elapsed;
    logic                           turning;
    logic                           load;

    assign in_ready        = !m_valid_reg || m_ready;
    assign load            = in_valid && in_ready;
    assign m_valid         = m_valid_reg;
    assign m_drive_command = cmd_reg;
    assign m_drive_speed   = speed_reg;
    assign m_line_state    = state_reg;

    // classification, memory decides when no sensor or only the two outer sensors see the line
    always_comb begin
        unique case (in_data.pattern)
            lfps_pkg::PAT_LEFT:         st = lfps_pkg::ST_LEFT;
            lfps_pkg::PAT_CENTER:       st = lfps_pkg::ST_CENTER;
            lfps_pkg::PAT_RIGHT:        st = lfps_pkg::ST_RIGHT;
            lfps_pkg::PAT_CENTER_LEFT:  st = lfps_pkg::ST_CENTER_LEFT;
            lfps_pkg::PAT_CENTER_RIGHT: st = lfps_pkg::ST_CENTER_RIGHT;
            lfps_pkg::PAT_ALL:          st = lfps_pkg::ST_LOST;
            lfps_pkg::PAT_NONE, lfps_pkg::PAT_OUTER: begin
                unique case (last_seen_reg) inside
                    lfps_pkg::ST_LEFT, lfps_pkg::ST_CENTER_LEFT:
                        st = lfps_pkg::ST_LOST_LEFT;
                    lfps_pkg::ST_RIGHT, lfps_pkg::ST_CENTER_RIGHT:
                        st = lfps_pkg::ST_LOST_RIGHT;
                    default:
                        st = lfps_pkg::ST_LOST;
                endcase
            end
            default:                    st = lfps_pkg::ST_LOST;
        endcase
    end

    assign eff_start = running_reg ? start_reg : in_data.now_ms;
    assign elapsed   = in_data.now_ms - eff_start;
    assign turning   = elapsed < {{(lfps_pkg::TIME_W - lfps_pkg::PULSE_W){1'b0}},
                                  cfg.pulse_length_ms};

    always_comb begin
        last_seen_next = last_seen_reg;
        running_next   = running_reg;
        start_next     = start_reg;
        m_valid_next   = m_valid_reg;
        cmd_next       = cmd_reg;
        speed_next     = speed_reg;
        state_next     = state_reg;
        if (load) begin
            m_valid_next = 1'b1;
            state_next   = st;
            if (st != lfps_pkg::ST_LOST_LEFT && st != lfps_pkg::ST_LOST_RIGHT &&
                st != lfps_pkg::ST_LOST) begin
                last_seen_next = st;
            end
            unique case (st) inside
                lfps_pkg::ST_CENTER: begin
                    running_next = 1'b0;
                    cmd_next     = lfps_pkg::CMD_FORWARD;
                    speed_next   = cfg.straight_speed;
                end
                lfps_pkg::ST_LOST: begin
                    running_next = 1'b0;
                    cmd_next     = lfps_pkg::CMD_STOP;
                    speed_next   = '0;
                end
                lfps_pkg::ST_LOST_LEFT: begin
                    running_next = 1'b0;
                    cmd_next     = lfps_pkg::CMD_LEFT;
                    speed_next   = cfg.turn_speed;
                end
                lfps_pkg::ST_LOST_RIGHT: begin
                    running_next = 1'b0;
                    cmd_next     = lfps_pkg::CMD_RIGHT;
                    speed_next   = cfg.turn_speed;
                end
                default: begin
                    start_next = eff_start;
                    if (turning) begin
                        running_next = 1'b1;
                        cmd_next     = (st == lfps_pkg::ST_LEFT ||
                                        st == lfps_pkg::ST_CENTER_LEFT) ?
                                       lfps_pkg::CMD_LEFT : lfps_pkg::CMD_RIGHT;
                        speed_next   = cfg.turn_speed;
                    end else begin
                        running_next = 1'b0;
                        cmd_next     = lfps_pkg::CMD_FORWARD;
                        speed_next   = cfg.straight_speed;
                    end
                end
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seen_reg <= lfps_pkg::ST_LOST;
            running_reg   <= 1'b0;
            start_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            last_seen_reg <= last_seen_next;
            running_reg   <= running_next;
            start_reg     <= start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        speed_reg <= speed_next;
        state_reg <= state_next;
    end

    a_stop_means_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && cmd_reg == lfps_pkg::CMD_STOP |->
            speed_reg == '0 && state_reg == lfps_pkg::ST_LOST)
        else $error("stop issued without lost state or with nonzero speed");

    a_center_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && state_reg == lfps_pkg::ST_CENTER |->
            cmd_reg == lfps_pkg::CMD_FORWARD)
        else $error("center state did not drive forward");

    a_pulse_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (st == lfps_pkg::ST_CENTER || st == lfps_pkg::ST_LOST ||
                 st == lfps_pkg::ST_LOST_LEFT || st == lfps_pkg::ST_LOST_RIGHT)
        |=> !running_reg)
        else $error("pulse still running after center or lost state");

    a_memory_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (st == lfps_pkg::ST_LOST || st == lfps_pkg::ST_LOST_LEFT ||
                 st == lfps_pkg::ST_LOST_RIGHT) |=> $stable(last_seen_reg))
        else $error("last seen side changed on a lost state");

endmodule

// ----- design/line_follow_pulse_steering_unit.sv -----
// top level of the line follow pulse steering unit
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    sensor_left, sensor_middle, sensor_right, now_ms
//  m_       out        m_valid/m_ready    drive_command, drive_speed, line_state
//  cfg_     in         cfg_wr_en          cfg_addr, cfg_wdata
//
// one transaction per cycle sustained while m_ready stays high; a transaction passes from s_ to m_
// through the threshold register, the queue entry and the result register
// the back stage holds pulse and last-seen state and updates it once per transaction
// a two-entry queue lets the front keep taking transactions while m_ready is low
// reset clears control and restores the register defaults, no clearing pass
module line_follow_pulse_steering_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lfps_pkg::SAMPLE_W-1:0]   s_sensor_left,
    input  logic [lfps_pkg::SAMPLE_W-1:0]   s_sensor_middle,
    input  logic [lfps_pkg::SAMPLE_W-1:0]   s_sensor_right,
    input  logic [lfps_pkg::TIME_W-1:0]     s_now_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_drive_command,
    output logic [lfps_pkg::SPEED_W-1:0]    m_drive_speed,
    output logic [2:0]                      m_line_state,
    input  logic                            cfg_wr_en,
    input  logic [lfps_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [lfps_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [lfps_pkg::SAMPLE_W-1:0] threshold_next;
    lfps_pkg::drive_cfg_t          drive_cfg_reg;
    lfps_pkg::drive_cfg_t          drive_cfg_next;

    logic              fq_valid;
    logic              fq_ready;
    lfps_pkg::sample_t fq_data;
    logic              qb_valid;
    logic              qb_ready;
    lfps_pkg::sample_t qb_data;

    always_comb begin
        threshold_next = threshold_reg;
        drive_cfg_next = drive_cfg_reg;
        if (cfg_wr_en) begin
            unique case (lfps_pkg::cfg_reg_t'(cfg_addr))
                lfps_pkg::REG_DETECT_LEVEL:
                    threshold_next = cfg_wdata[lfps_pkg::SAMPLE_W-1:0];
                lfps_pkg::REG_PULSE_LENGTH_MS:
                    drive_cfg_next.pulse_length_ms = cfg_wdata[lfps_pkg::PULSE_W-1:0];
                lfps_pkg::REG_TURN_SPEED:
                    drive_cfg_next.turn_speed = cfg_wdata[lfps_pkg::SPEED_W-1:0];
                lfps_pkg::REG_STRAIGHT_SPEED:
                    drive_cfg_next.straight_speed = cfg_wdata[lfps_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg                 <= lfps_pkg::THRESHOLD_RST;
            drive_cfg_reg.pulse_length_ms <= lfps_pkg::PULSE_LEN_RST;
            drive_cfg_reg.turn_speed      <= lfps_pkg::TURN_SPD_RST;
            drive_cfg_reg.straight_speed  <= lfps_pkg::STRAIGHT_SPD_RST;
        end else begin
            threshold_reg <= threshold_next;
            drive_cfg_reg <= drive_cfg_next;
        end
    end

    lfps_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_left   (s_sensor_left),
        .s_sensor_middle (s_sensor_middle),
        .s_sensor_right  (s_sensor_right),
        .s_now_ms        (s_now_ms),
        .detect_level    (threshold_reg),
        .out_valid       (fq_valid),
        .out_ready       (fq_ready),
        .out_data        (fq_data)
    );

    lfps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    lfps_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (drive_cfg_reg),
        .in_valid        (qb_valid),
        .in_ready        (qb_ready),
        .in_data         (qb_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_command (m_drive_command),
        .m_drive_speed   (m_drive_speed),
        .m_line_state    (m_line_state)
    );

endmodule

// ----- bench/line_follow_pulse_steering_unit_test.sv -----
// self-checking testbench for the line follow pulse steering unit
module line_follow_pulse_steering_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    typedef struct {
        drive_cmd_t         cmd;
        logic [SPEED_W-1:0] speed;
        line_state_t        state;
    } drive_result_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sensor_left   = '0;
    logic [SAMPLE_W-1:0]   s_sensor_middle = '0;
    logic [SAMPLE_W-1:0]   s_sensor_right  = '0;
    logic [TIME_W-1:0]     s_now_ms        = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [1:0]            m_drive_command;
    logic [SPEED_W-1:0]    m_drive_speed;
    logic [2:0]            m_line_state;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr        = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

    // steering predictor state
    logic [SAMPLE_W-1:0] thr_reg          = THRESHOLD_RST;
    logic [PULSE_W-1:0]  pulse_len_reg    = PULSE_LEN_RST;
    logic [SPEED_W-1:0]  turn_spd_reg     = TURN_SPD_RST;
    logic [SPEED_W-1:0]  straight_spd_reg = STRAIGHT_SPD_RST;
    line_state_t         seen_side        = ST_LOST;
    bit                  pulse_on         = 1'b0;
    logic [TIME_W-1:0]   pulse_t0         = '0;

    drive_result_t pending_drive[$];
    int fail_count     = 0;
    int sensor_txns    = 0;
    int drive_results  = 0;
    int settings_count = 0;
    bit steady         = 1'b0;

    line_follow_pulse_steering_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_left   (s_sensor_left),
        .s_sensor_middle (s_sensor_middle),
        .s_sensor_right  (s_sensor_right),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_command (m_drive_command),
        .m_drive_speed   (m_drive_speed),
        .m_line_state    (m_line_state),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 0;
    end

    task automatic steer_predict(input logic [SAMPLE_W-1:0] l, m, r,
                                 input logic [TIME_W-1:0] now);
        drive_result_t     res;
        logic [2:0]        pat;
        logic [TIME_W-1:0] elapsed;
        pat = {l > thr_reg, m > thr_reg, r > thr_reg};
        case (pat)
            PAT_LEFT:         res.state = ST_LEFT;
            PAT_CENTER:       res.state = ST_CENTER;
            PAT_RIGHT:        res.state = ST_RIGHT;
            PAT_CENTER_LEFT:  res.state = ST_CENTER_LEFT;
            PAT_CENTER_RIGHT: res.state = ST_CENTER_RIGHT;
            PAT_ALL:          res.state = ST_LOST;
            default: begin
                if (seen_side == ST_LEFT || seen_side == ST_CENTER_LEFT)
                    res.state = ST_LOST_LEFT;
                else if (seen_side == ST_RIGHT || seen_side == ST_CENTER_RIGHT)
                    res.state = ST_LOST_RIGHT;
                else
                    res.state = ST_LOST;
            end
        endcase
        if (!(res.state inside {ST_LOST_LEFT, ST_LOST_RIGHT, ST_LOST}))
            seen_side = res.state;
        case (res.state)
            ST_CENTER: begin
                pulse_on  = 1'b0;
                res.cmd   = CMD_FORWARD;
                res.speed = straight_spd_reg;
            end
            ST_LOST: begin
                pulse_on  = 1'b0;
                res.cmd   = CMD_STOP;
                res.speed = '0;
            end
            ST_LOST_LEFT: begin
                pulse_on  = 1'b0;
                res.cmd   = CMD_LEFT;
                res.speed = turn_spd_reg;
            end
            ST_LOST_RIGHT: begin
                pulse_on  = 1'b0;
                res.cmd   = CMD_RIGHT;
                res.speed = turn_spd_reg;
            end
            default: begin
                if (!pulse_on) begin
                    pulse_on = 1'b1;
                    pulse_t0 = now;
                end
                elapsed = now - pulse_t0;
                if (elapsed < TIME_W'(pulse_len_reg)) begin
                    res.cmd = (res.state == ST_LEFT || res.state == ST_CENTER_LEFT) ?
                              CMD_LEFT : CMD_RIGHT;
                    res.speed = turn_spd_reg;
                end else begin
                    pulse_on  = 1'b0;
                    res.cmd   = CMD_FORWARD;
                    res.speed = straight_spd_reg;
                end
            end
        endcase
        pending_drive.push_back(res);
    endtask

    task automatic send_item(input logic [SAMPLE_W-1:0] l, m, r,
                             input logic [TIME_W-1:0] now);
        s_valid         <= 1'b1;
        s_sensor_left   <= l;
        s_sensor_middle <= m;
        s_sensor_right  <= r;
        s_now_ms        <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        steer_predict(l, m, r, now);
        sensor_txns++;
        if (!steady && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic write_regs(input logic [SAMPLE_W-1:0] thr, input logic [PULSE_W-1:0] plen,
                              input logic [SPEED_W-1:0] turn, straight);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DETECT_LEVEL;
        cfg_wdata <= {4'($urandom), thr};
        @(posedge aclk);
        cfg_addr  <= REG_PULSE_LENGTH_MS;
        cfg_wdata <= plen;
        @(posedge aclk);
        cfg_addr  <= REG_TURN_SPEED;
        cfg_wdata <= {8'($urandom), turn};
        @(posedge aclk);
        cfg_addr  <= REG_STRAIGHT_SPEED;
        cfg_wdata <= {8'($urandom), straight};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        thr_reg          = thr;
        pulse_len_reg    = plen;
        turn_spd_reg     = turn;
        straight_spd_reg = straight;
        settings_count++;
    endtask

    task automatic wait_idle;
        s_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit hit);
        if (hit && thr_reg != '1)
            return SAMPLE_W'($urandom_range(4095, int'(thr_reg) + 1));
        return SAMPLE_W'($urandom_range(int'(thr_reg), 0));
    endfunction

    // mostly held line patterns with a running clock, plus noise and time jumps
    task automatic run_track(input int count, input int step_max, input logic [TIME_W-1:0] t0);
        logic [2:0]          pat;
        logic [TIME_W-1:0]   t;
        logic [SAMPLE_W-1:0] l, m, r;
        int                  roll;
        int                  k;
        pat = PAT_CENTER;
        t   = t0;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    case ($urandom_range(3))
                        0:       pat = PAT_LEFT;
                        1:       pat = PAT_CENTER_LEFT;
                        2:       pat = PAT_RIGHT;
                        default: pat = PAT_CENTER_RIGHT;
                    endcase
                end else if (roll < 70) begin
                    pat = PAT_CENTER;
                end else if (roll < 85) begin
                    pat = $urandom_range(1) ? PAT_NONE : PAT_OUTER;
                end else if (roll < 92) begin
                    pat = PAT_ALL;
                end else begin
                    pat = 3'($urandom);
                end
            end
            roll = $urandom_range(99);
            if (roll < 3)
                t = $urandom;
            else if (roll < 6)
                t = t - $urandom_range(50, 1);
            else
                t = t + $urandom_range(step_max, 0);
            if ($urandom_range(99) < 5) begin
                l = 12'($urandom);
                m = 12'($urandom);
                r = 12'($urandom);
            end else begin
                l = pick_sample(pat[2]);
                m = pick_sample(pat[1]);
                r = pick_sample(pat[0]);
            end
            send_item(l, m, r, t);
        end
    endtask

    task automatic test_classify_defaults;
        send_item(12'd0, 12'd0, 12'd0, 32'd0);
        send_item(12'd4095, 12'd0, 12'd0, 32'hFFFF_FFFF);
        send_item(12'd0, 12'd0, 12'd0, 32'd5);
        send_item(12'd2001, 12'd2001, 12'd0, 32'd10);
        send_item(12'd2001, 12'd2001, 12'd0, 32'd109);
        send_item(12'd2001, 12'd2001, 12'd0, 32'd110);
        send_item(12'd2001, 12'd2001, 12'd0, 32'd111);
        send_item(12'd2000, 12'd4095, 12'd2000, 32'd120);
        send_item(12'd4095, 12'd0, 12'd4095, 32'd130);
        send_item(12'd0, 12'd0, 12'd2001, 32'd200);
        send_item(12'd4095, 12'd0, 12'd4095, 32'd210);
        send_item(12'd0, 12'd4095, 12'd4095, 32'd300);
        send_item(12'd0, 12'd4095, 12'd4095, 32'd299);
        send_item(12'd4095, 12'd4095, 12'd4095, 32'd310);
        send_item(12'd0, 12'd0, 12'd0, 32'd320);
        wait_idle;
    endtask

    task automatic test_register_extremes;
        write_regs(12'd0, 16'd0, 8'd0, 8'd255);
        send_item(12'd1, 12'd0, 12'd0, 32'd1000);
        send_item(12'd0, 12'd1, 12'd0, 32'd1001);
        send_item(12'd0, 12'd0, 12'd0, 32'd1002);
        wait_idle;
        write_regs(12'd4095, 16'hFFFF, 8'd255, 8'd0);
        send_item(12'd4095, 12'd4095, 12'd4095, 32'd2000);
        send_item(12'd4094, 12'd4094, 12'd4094, 32'd2001);
        wait_idle;
        write_regs(12'd4094, 16'hFFFF, 8'd255, 8'd0);
        send_item(12'd4095, 12'd0, 12'd0, 32'd0);
        send_item(12'd4095, 12'd0, 12'd0, 32'd65534);
        send_item(12'd4095, 12'd0, 12'd0, 32'd65535);
        wait_idle;
    endtask

    task automatic test_random_tracks;
        int ph;
        logic [SAMPLE_W-1:0] thr;
        write_regs(THRESHOLD_RST, PULSE_LEN_RST, 8'($urandom), 8'($urandom));
        run_track(150, 40, $urandom);
        wait_idle;
        steady = 1'b1;
        write_regs(12'($urandom_range(4000, 100)), 16'($urandom_range(300, 1)),
                   8'($urandom), 8'($urandom));
        run_track(120, 100, 32'hFFFF_FE00);
        wait_idle;
        steady = 1'b0;
        write_regs(12'($urandom_range(4000, 100)), 16'hFFFF, 8'd255, 8'd0);
        run_track(100, 30000, $urandom);
        wait_idle;
        write_regs(12'($urandom_range(4000, 100)), 16'd0, 8'($urandom), 8'($urandom));
        run_track(60, 20, $urandom);
        for (ph = 0; ph < 5; ph++) begin
            wait_idle;
            case ($urandom_range(5))
                0:       thr = 12'd0;
                1:       thr = 12'd4095;
                default: thr = 12'($urandom);
            endcase
            write_regs(thr, 16'($urandom_range(500, 0)), 8'($urandom), 8'($urandom));
            run_track(50, $urandom_range(200, 5), $urandom);
        end
        wait_idle;
    endtask

    // result checker and random back-pressure
    always @(posedge aclk) begin
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            drive_results++;
            if (pending_drive.size() == 0) begin
                $display("%0t: unexpected transaction cmd %0d speed %0d state %0d",
                         $time, m_drive_command, m_drive_speed, m_line_state);
                fail_count++;
            end else begin
                want = pending_drive.pop_front();
                if (m_drive_command !== want.cmd) begin
                    $display("%0t: drive_command expected %0d actual %0d",
                             $time, want.cmd, m_drive_command);
                    fail_count++;
                end
                if (m_drive_speed !== want.speed) begin
                    $display("%0t: drive_speed expected %0d actual %0d",
                             $time, want.speed, m_drive_speed);
                    fail_count++;
                end
                if (m_line_state !== want.state) begin
                    $display("%0t: line_state expected %0d actual %0d",
                             $time, want.state, m_line_state);
                    fail_count++;
                end
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 25);
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_classify_defaults;
        test_register_extremes;
        test_random_tracks;
        $display("Checked %0d drive results from %0d sensor transactions",
                 drive_results, sensor_txns);
        $display("Register settings used: %0d, covering threshold, pulse and speed extremes",
                 settings_count + 1);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_drive.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
